// File: hw/rtl/bezier_ribbon_tessellator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ribbon tessellator
// Implication checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BEZIER_RIBBON_TESSELLATOR_CORE_MACROS_SVH
`define BEZIER_RIBBON_TESSELLATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define BRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRT_ASSERT_IMP(lbl, ante, cons, msg)
`define BRT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/brt_pkg.sv
// ----------------------------------------------------------------------------
// Ribbon tessellator package
// Shared widths, codes, request and response types.
// ----------------------------------------------------------------------------
package brt_pkg;

    localparam int COORD_W     = 32;
    localparam int THICK_W     = 31;
    localparam int STEPS_W     = 5;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;
    localparam int CORNER_W    = 2;

    // Datapath widths of the shared sample unit.
    localparam int COEF_W  = 17;
    localparam int DCUBE_W = 15;
    localparam int SQ_W    = 10;
    localparam int EC_W    = 11;
    localparam int MUL_W   = 34;
    localparam int ACC_W   = 64;
    localparam int TAN_W   = 46;
    localparam int ABS_W   = 46;
    localparam int NORM_W  = 30;
    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 33;
    localparam int RAD_W   = 62;
    localparam int ROOT_W  = 31;

    localparam logic [THICK_W-1:0] THICK_RESET = 31'd65536;
    localparam logic [STEPS_W-1:0] STEPS_RESET = 5'd12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THICKNESS = 4'd0,
        CFG_STEPS     = 4'd1
    } cfg_index_t;

    typedef enum logic [CORNER_W-1:0] {
        CORNER_CUR_MINUS = 2'd0,
        CORNER_CUR_PLUS  = 2'd1,
        CORNER_NXT_PLUS  = 2'd2,
        CORNER_NXT_MINUS = 2'd3
    } corner_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] ctrl1_x;
        logic signed [COORD_W-1:0] ctrl1_y;
        logic signed [COORD_W-1:0] ctrl1_z;
        logic signed [COORD_W-1:0] ctrl2_x;
        logic signed [COORD_W-1:0] ctrl2_y;
        logic signed [COORD_W-1:0] ctrl2_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } seg_req_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_req_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic [CORNER_W-1:0]       corner;
        logic                      degenerate;
        logic                      last;
    } vertex_t;

    typedef struct packed {
        logic [STEPS_W-1:0] k;
        logic [STEPS_W-1:0] n;
    } sample_req_t;

    typedef struct packed {
        point_t                    pt;
        logic signed [COORD_W-1:0] off_x;
        logic signed [COORD_W-1:0] off_y;
        logic                      deg;
    } sample_rsp_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_START,
        TOP_WAIT,
        TOP_EMIT
    } top_state_t;

    typedef enum logic [3:0] {
        SMP_IDLE,
        SMP_COEF1,
        SMP_COEF2,
        SMP_MUL,
        SMP_ACC,
        SMP_POST,
        SMP_DIV_GO,
        SMP_DIV_WAIT,
        SMP_NORM,
        SMP_SQRT_WAIT,
        SMP_DONE
    } smp_state_t;

    typedef enum logic [2:0] {
        PH_PX,
        PH_PY,
        PH_PZ,
        PH_DX,
        PH_DY,
        PH_SQ,
        PH_MX,
        PH_MY
    } smp_phase_t;

endpackage

// File: hw/rtl/brt_stream_if.sv
// ----------------------------------------------------------------------------
// Ribbon tessellator stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface brt_stream_if #(parameter type payload_t = logic) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// File: hw/rtl/brt_divider.sv
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulses when finished.
// ----------------------------------------------------------------------------
module brt_divider
    import brt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               done,
    output logic [DIV_N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dsr_reg, dsr_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;

    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    // One restoring step: bring in the next dividend bit and try a subtract.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DIV_N_W-1]};
        trial   = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/brt_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module brt_isqrt
    import brt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [RAD_W-1:0] v_reg, v_next;
    logic [RAD_W-1:0] r_reg, r_next;
    logic [RAD_W-1:0] b_reg, b_next;

    logic [RAD_W-1:0] trial;

    assign trial = r_reg + b_reg;

    // Each step settles one bit of the root, walking the test bit down two places.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            v_next    = radicand;
            r_next    = '0;
            b_next    = RAD_W'(1) << (RAD_W - 2);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + b_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            b_next = b_reg >> 2;
            if (b_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        r_reg <= r_next;
        b_reg <= b_next;
    end

    assign done = done_reg;
    assign root = r_reg[ROOT_W-1:0];

endmodule

// File: hw/rtl/brt_sampler.sv
// ----------------------------------------------------------------------------
// Curve sample unit
// Computes point, side offset and degenerate flag at t = k/n using one
// shared multiplier with accumulator, a divider and a square root unit.
// ----------------------------------------------------------------------------
module brt_sampler
    import brt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  sample_req_t        req,
    input  point_t             pts [4],
    input  logic [THICK_W-1:0] thickness,
    output logic               done,
    output sample_rsp_t        rsp
);

    smp_state_t state_reg, state_next;
    smp_phase_t phase_reg, phase_next;
    logic [1:0] idx_reg, idx_next;

    logic [STEPS_W-1:0] k_reg, k_next;
    logic [STEPS_W-1:0] n_reg, n_next;
    logic [SQ_W-1:0]    uu_reg, uu_next;
    logic [SQ_W-1:0]    kk_reg, kk_next;
    logic [SQ_W-1:0]    uk_reg, uk_next;
    logic [SQ_W-1:0]    nn_reg, nn_next;
    logic [COEF_W-1:0]  c_reg [4];
    logic [COEF_W-1:0]  c_next [4];
    logic [EC_W-1:0]    e_reg [3];
    logic [EC_W-1:0]    e_next [3];
    logic [DCUBE_W-1:0] d_reg, d_next;

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [TAN_W-1:0] dx_reg, dx_next;
    logic signed [TAN_W-1:0] dy_reg, dy_next;
    logic [ABS_W-1:0]        ax_reg, ax_next;
    logic [ABS_W-1:0]        ay_reg, ay_next;
    logic [ROOT_W-1:0]       len_reg, len_next;
    logic                    neg_reg, neg_next;
    sample_rsp_t             rsp_reg, rsp_next;

    logic [STEPS_W-1:0]      u;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic [1:0]              idx_last;
    point_t                  p_lo;
    point_t                  p_hi;
    logic signed [TAN_W-1:0] dy_cur;
    logic                    tan_zero;
    logic [ABS_W-1:0]        m_val;
    logic                    norm_ok;

    logic               div_start;
    logic [DIV_N_W-1:0] div_dividend;
    logic [DIV_D_W-1:0] div_divisor;
    logic               div_done;
    logic [DIV_N_W-1:0] div_quotient;
    logic [COORD_W:0]   q_mag;
    logic [COORD_W:0]   q_signed;

    logic               sqrt_start;
    logic               sqrt_done;
    logic [ROOT_W-1:0]  sqrt_root;

    brt_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    brt_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (acc_reg[RAD_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign u = n_reg - k_reg;

    // Helper terms for the tangent, degenerate test and normalization.
    always_comb
    begin
        p_lo     = pts[idx_reg];
        p_hi     = pts[idx_reg + 2'd1];
        dy_cur   = acc_reg[TAN_W-1:0];
        tan_zero = (dx_reg == '0) && (dy_cur == '0);
        m_val    = (ax_reg > ay_reg) ? ax_reg : ay_reg;
        norm_ok  = (m_val[ABS_W-1:NORM_W] == '0) && m_val[NORM_W-1];
        q_mag    = div_quotient[COORD_W:0];
        q_signed = neg_reg ? -q_mag : q_mag;
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        idx_last = 2'd0;
        case (phase_reg)
            PH_PX:
            begin
                mul_a    = $signed(MUL_W'(c_reg[idx_reg]));
                mul_b    = MUL_W'(pts[idx_reg].x);
                idx_last = 2'd3;
            end
            PH_PY:
            begin
                mul_a    = $signed(MUL_W'(c_reg[idx_reg]));
                mul_b    = MUL_W'(pts[idx_reg].y);
                idx_last = 2'd3;
            end
            PH_PZ:
            begin
                mul_a    = $signed(MUL_W'(c_reg[idx_reg]));
                mul_b    = MUL_W'(pts[idx_reg].z);
                idx_last = 2'd3;
            end
            PH_DX:
            begin
                mul_a    = $signed(MUL_W'(e_reg[idx_reg]));
                mul_b    = MUL_W'(p_hi.x) - MUL_W'(p_lo.x);
                idx_last = 2'd2;
            end
            PH_DY:
            begin
                mul_a    = $signed(MUL_W'(e_reg[idx_reg]));
                mul_b    = MUL_W'(p_hi.y) - MUL_W'(p_lo.y);
                idx_last = 2'd2;
            end
            PH_SQ:
            begin
                mul_a    = $signed(MUL_W'(idx_reg[0] ? ay_reg[NORM_W-1:0]
                                                     : ax_reg[NORM_W-1:0]));
                mul_b    = mul_a;
                idx_last = 2'd1;
            end
            PH_MX:
            begin
                mul_a    = $signed(MUL_W'(thickness));
                mul_b    = $signed(MUL_W'(ay_reg[NORM_W-1:0]));
                idx_last = 2'd0;
            end
            PH_MY:
            begin
                mul_a    = $signed(MUL_W'(thickness));
                mul_b    = $signed(MUL_W'(ax_reg[NORM_W-1:0]));
                idx_last = 2'd0;
            end
            default:
            begin
                mul_a    = '0;
                mul_b    = '0;
                idx_last = 2'd0;
            end
        endcase
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SMP_IDLE:      if (start) state_next = SMP_COEF1;
            SMP_COEF1:     state_next = SMP_COEF2;
            SMP_COEF2:     state_next = SMP_MUL;
            SMP_MUL:       state_next = SMP_ACC;
            SMP_ACC:       state_next = (idx_reg == idx_last) ? SMP_POST : SMP_MUL;
            SMP_POST:
            begin
                case (phase_reg)
                    PH_DX:   state_next = SMP_MUL;
                    PH_DY:   state_next = tan_zero ? SMP_DONE : SMP_NORM;
                    PH_SQ:   state_next = SMP_SQRT_WAIT;
                    default: state_next = SMP_DIV_GO;
                endcase
            end
            SMP_DIV_GO:    state_next = SMP_DIV_WAIT;
            SMP_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (phase_reg == PH_MY) ? SMP_DONE : SMP_MUL;
            end
            SMP_NORM:      if (norm_ok) state_next = SMP_MUL;
            SMP_SQRT_WAIT: if (sqrt_done) state_next = SMP_MUL;
            SMP_DONE:      state_next = SMP_IDLE;
            default:       state_next = SMP_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        done       = (state_reg == SMP_DONE);
        div_start  = (state_reg == SMP_DIV_GO);
        sqrt_start = (state_reg == SMP_POST) && (phase_reg == PH_SQ);
    end

    // Divider operands: the point rounds toward minus infinity on a
    // magnitude, the offsets divide by twice the length.
    always_comb
    begin
        if ((phase_reg == PH_MX) || (phase_reg == PH_MY))
        begin
            div_dividend = acc_reg;
            div_divisor  = DIV_D_W'({len_reg, 1'b0});
        end
        else
        begin
            div_dividend = acc_reg[ACC_W-1] ? (~acc_reg + ACC_W'(d_reg)) : acc_reg;
            div_divisor  = DIV_D_W'(d_reg);
        end
    end

    // Datapath registers.
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        uu_next    = uu_reg;
        kk_next    = kk_reg;
        uk_next    = uk_reg;
        nn_next    = nn_reg;
        c_next     = c_reg;
        e_next     = e_reg;
        d_next     = d_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        len_next   = len_reg;
        neg_next   = neg_reg;
        rsp_next   = rsp_reg;
        case (state_reg)
            SMP_IDLE:
            begin
                k_next = req.k;
                n_next = req.n;
            end
            SMP_COEF1:
            begin
                uu_next = SQ_W'(u) * SQ_W'(u);
                kk_next = SQ_W'(k_reg) * SQ_W'(k_reg);
                uk_next = SQ_W'(u) * SQ_W'(k_reg);
                nn_next = SQ_W'(n_reg) * SQ_W'(n_reg);
            end
            SMP_COEF2:
            begin
                c_next[0]  = COEF_W'(uu_reg) * COEF_W'(u);
                c_next[1]  = COEF_W'(uu_reg) * COEF_W'(k_reg) * COEF_W'(3);
                c_next[2]  = COEF_W'(uk_reg) * COEF_W'(k_reg) * COEF_W'(3);
                c_next[3]  = COEF_W'(kk_reg) * COEF_W'(k_reg);
                e_next[0]  = EC_W'(uu_reg);
                e_next[1]  = EC_W'({uk_reg, 1'b0});
                e_next[2]  = EC_W'(kk_reg);
                d_next     = DCUBE_W'(nn_reg) * DCUBE_W'(n_reg);
                phase_next = PH_PX;
                idx_next   = 2'd0;
                acc_next   = '0;
            end
            SMP_MUL:
            begin
                prod_next = ACC_W'(mul_a * mul_b);
            end
            SMP_ACC:
            begin
                acc_next = acc_reg + prod_reg;
                if (idx_reg != idx_last)
                    idx_next = idx_reg + 2'd1;
            end
            SMP_POST:
            begin
                case (phase_reg)
                    PH_PX, PH_PY, PH_PZ:
                    begin
                        acc_next = acc_reg + $signed(ACC_W'(d_reg >> 1));
                    end
                    PH_DX:
                    begin
                        dx_next    = acc_reg[TAN_W-1:0];
                        phase_next = PH_DY;
                        idx_next   = 2'd0;
                        acc_next   = '0;
                    end
                    PH_DY:
                    begin
                        dy_next = dy_cur;
                        if (tan_zero)
                        begin
                            rsp_next.off_x = '0;
                            rsp_next.off_y = '0;
                            rsp_next.deg   = 1'b1;
                        end
                        else
                        begin
                            rsp_next.deg = 1'b0;
                            ax_next = dx_reg[TAN_W-1] ? ABS_W'(-dx_reg) : ABS_W'(dx_reg);
                            ay_next = dy_cur[TAN_W-1] ? ABS_W'(-dy_cur) : ABS_W'(dy_cur);
                        end
                    end
                    PH_MX, PH_MY:
                    begin
                        acc_next = acc_reg + $signed(ACC_W'(len_reg));
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            SMP_DIV_GO:
            begin
                neg_next = acc_reg[ACC_W-1];
            end
            SMP_DIV_WAIT:
            begin
                if (div_done)
                begin
                    phase_next = phase_reg;
                    idx_next   = 2'd0;
                    acc_next   = '0;
                    case (phase_reg)
                        PH_PX:
                        begin
                            rsp_next.pt.x = q_signed[COORD_W-1:0];
                            phase_next    = PH_PY;
                        end
                        PH_PY:
                        begin
                            rsp_next.pt.y = q_signed[COORD_W-1:0];
                            phase_next    = PH_PZ;
                        end
                        PH_PZ:
                        begin
                            rsp_next.pt.z = q_signed[COORD_W-1:0];
                            phase_next    = PH_DX;
                        end
                        PH_MX:
                        begin
                            // The x offset follows the sign of the y tangent.
                            rsp_next.off_x = dy_reg[TAN_W-1] ? -q_mag[COORD_W-1:0]
                                                             : q_mag[COORD_W-1:0];
                            phase_next     = PH_MY;
                        end
                        PH_MY:
                        begin
                            // The y offset is negative for a rising x tangent.
                            rsp_next.off_y = (!dx_reg[TAN_W-1] && (dx_reg != '0))
                                             ? -q_mag[COORD_W-1:0] : q_mag[COORD_W-1:0];
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            SMP_NORM:
            begin
                // Scale both magnitudes until the larger lies in one octave.
                if (norm_ok)
                begin
                    phase_next = PH_SQ;
                    idx_next   = 2'd0;
                    acc_next   = '0;
                end
                else if (m_val[ABS_W-1:NORM_W] != '0)
                begin
                    ax_next = ax_reg >> 1;
                    ay_next = ay_reg >> 1;
                end
                else
                begin
                    ax_next = ax_reg << 1;
                    ay_next = ay_reg << 1;
                end
            end
            SMP_SQRT_WAIT:
            begin
                if (sqrt_done)
                begin
                    len_next   = sqrt_root;
                    phase_next = PH_MX;
                    idx_next   = 2'd0;
                    acc_next   = '0;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SMP_IDLE;
            phase_reg <= PH_PX;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        n_reg    <= n_next;
        uu_reg   <= uu_next;
        kk_reg   <= kk_next;
        uk_reg   <= uk_next;
        nn_reg   <= nn_next;
        c_reg    <= c_next;
        e_reg    <= e_next;
        d_reg    <= d_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        len_reg  <= len_next;
        neg_reg  <= neg_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

// File: hw/rtl/bezier_ribbon_tessellator_core.sv
// Each curve sample uses the shared 64-step divider (five divisions per sample,
// three when the xy tangent is zero) and, unless that tangent is zero, the
// 31-step square root. A segment of n quads needs n+1 samples; each quad then
// leaves as four vertices, and the block takes one segment at a time.
// Reset (rst_n low, asynchronous) sets thickness to 1.0 and steps to 12.
// ----------------------------------------------------------------------------
// Cubic Bezier ribbon tessellator
// Samples a segment at t = k/n and emits four ribbon vertices per interval.
// ----------------------------------------------------------------------------
`include "bezier_ribbon_tessellator_core_macros.svh"

module bezier_ribbon_tessellator_core
    import brt_pkg::*;
#(
    parameter int MAX_STEPS = 16
)
(
    input logic          clk,
    input logic          rst_n,
    brt_stream_if.sink   cfg,
    brt_stream_if.sink   seg,
    brt_stream_if.source vtx
);

    localparam int K_W = $clog2(MAX_STEPS + 1);

    top_state_t         state_reg, state_next;
    logic [THICK_W-1:0] thick_reg, thick_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    point_t             pts_reg [4];
    point_t             pts_next [4];
    logic [K_W-1:0]     n_reg, n_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic               first_reg, first_next;
    sample_rsp_t        cur_reg, cur_next;
    sample_rsp_t        nxt_reg, nxt_next;
    logic [CORNER_W-1:0] corner_reg, corner_next;
    logic               vout_valid_reg, vout_valid_next;
    vertex_t            vout_reg, vout_next;

    logic               seg_ready;
    logic               seg_take;
    logic               cfg_take;
    logic               smp_start;
    logic               smp_done;
    sample_req_t        smp_req;
    sample_rsp_t        smp_rsp;
    logic               load;
    logic               final_quad;
    logic [K_W-1:0]     n_clamped;
    sample_rsp_t        src;
    logic               minus;
    vertex_t            vert;

    // Saturating add or subtract of a point coordinate and a signed offset.
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] pt,
        input logic signed [COORD_W-1:0] off,
        input logic                      sub
    );
        logic signed [COORD_W:0] sum;
        sum = sub ? ((COORD_W+1)'(pt) - (COORD_W+1)'(off))
                  : ((COORD_W+1)'(pt) + (COORD_W+1)'(off));
        if (sum[COORD_W] != sum[COORD_W-1])
            sat_add = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                   : {1'b0, {(COORD_W-1){1'b1}}};
        else
            sat_add = sum[COORD_W-1:0];
    endfunction

    brt_sampler u_sampler (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (smp_start),
        .req       (smp_req),
        .pts       (pts_reg),
        .thickness (thick_reg),
        .done      (smp_done),
        .rsp       (smp_rsp)
    );

    assign cfg.ready = 1'b1;
    assign cfg_take  = cfg.valid;
    assign seg_take  = seg.valid && seg_ready;
    assign seg.ready = seg_ready;

    // Step count limited to one through the largest supported count.
    always_comb
    begin
        if (steps_reg == '0)
            n_clamped = K_W'(1);
        else if (32'(steps_reg) > MAX_STEPS)
            n_clamped = K_W'(MAX_STEPS);
        else
            n_clamped = K_W'(steps_reg);
    end

    assign final_quad = (k_reg == K_W'(n_reg - 1'b1));

    // Vertex for the current corner of the quad.
    always_comb
    begin
        src   = (corner_reg == CORNER_CUR_MINUS || corner_reg == CORNER_CUR_PLUS)
                ? cur_reg : nxt_reg;
        minus = (corner_reg == CORNER_CUR_MINUS || corner_reg == CORNER_NXT_MINUS);
        vert.vertex_x   = sat_add(src.pt.x, src.off_x, minus);
        vert.vertex_y   = sat_add(src.pt.y, src.off_y, minus);
        vert.vertex_z   = src.pt.z;
        vert.corner     = corner_reg;
        vert.degenerate = src.deg;
        vert.last       = (corner_reg == CORNER_NXT_MINUS) && final_quad;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TOP_IDLE:  if (seg_take) state_next = TOP_START;
            TOP_START: state_next = TOP_WAIT;
            TOP_WAIT:  if (smp_done) state_next = first_reg ? TOP_START : TOP_EMIT;
            TOP_EMIT:
            begin
                if (load && (corner_reg == CORNER_NXT_MINUS))
                    state_next = final_quad ? TOP_IDLE : TOP_START;
            end
            default:   state_next = TOP_IDLE;
        endcase
    end

    // State machine outputs.
    always_comb
    begin
        seg_ready = (state_reg == TOP_IDLE);
        smp_start = (state_reg == TOP_START);
        load      = (state_reg == TOP_EMIT) && (!vout_valid_reg || vtx.ready);
        smp_req.n = STEPS_W'(n_reg);
        smp_req.k = first_reg ? '0 : STEPS_W'(k_reg + 1'b1);
    end

    // Registers, sample storage and the output stage.
    always_comb
    begin
        thick_next      = thick_reg;
        steps_next      = steps_reg;
        pts_next        = pts_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        first_next      = first_reg;
        cur_next        = cur_reg;
        nxt_next        = nxt_reg;
        corner_next     = corner_reg;
        vout_next       = vout_reg;
        vout_valid_next = vout_valid_reg && !vtx.ready;

        if (cfg_take)
        begin
            case (cfg.payload.index)
                CFG_THICKNESS: thick_next = cfg.payload.data[THICK_W-1:0];
                CFG_STEPS:     steps_next = cfg.payload.data[STEPS_W-1:0];
                default:       thick_next = thick_reg;
            endcase
        end

        if (seg_take)
        begin
            pts_next[0] = '{seg.payload.start_x, seg.payload.start_y, seg.payload.start_z};
            pts_next[1] = '{seg.payload.ctrl1_x, seg.payload.ctrl1_y, seg.payload.ctrl1_z};
            pts_next[2] = '{seg.payload.ctrl2_x, seg.payload.ctrl2_y, seg.payload.ctrl2_z};
            pts_next[3] = '{seg.payload.end_x, seg.payload.end_y, seg.payload.end_z};
            n_next      = n_clamped;
            k_next      = '0;
            first_next  = 1'b1;
            corner_next = CORNER_CUR_MINUS;
        end

        if ((state_reg == TOP_WAIT) && smp_done)
        begin
            first_next = 1'b0;
            if (first_reg)
                cur_next = smp_rsp;
            else
                nxt_next = smp_rsp;
        end

        if (load)
        begin
            vout_next       = vert;
            vout_valid_next = 1'b1;
            corner_next     = corner_reg + 1'b1;
            if (corner_reg == CORNER_NXT_MINUS)
            begin
                cur_next = nxt_reg;
                k_next   = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= TOP_IDLE;
            thick_reg      <= THICK_RESET;
            steps_reg      <= STEPS_RESET;
            first_reg      <= 1'b0;
            corner_reg     <= CORNER_CUR_MINUS;
            k_reg          <= '0;
            n_reg          <= K_W'(1);
            vout_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thick_reg      <= thick_next;
            steps_reg      <= steps_next;
            first_reg      <= first_next;
            corner_reg     <= corner_next;
            k_reg          <= k_next;
            n_reg          <= n_next;
            vout_valid_reg <= vout_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pts_reg  <= pts_next;
        cur_reg  <= cur_next;
        nxt_reg  <= nxt_next;
        vout_reg <= vout_next;
    end

    assign vtx.valid   = vout_valid_reg;
    assign vtx.payload = vout_reg;

    // The last flag only rides on the closing corner of a quad.
    `BRT_ASSERT_IMP(a_last_on_close, vtx.valid && vtx.payload.last, vtx.payload.corner == CORNER_NXT_MINUS, "last flag on a corner other than the closing one")
    // A taken segment request keeps the block busy in the next cycle.
    `BRT_ASSERT_NXT(a_busy_after_seg, seg_take, !seg.ready, "segment request taken while still ready")
    // Sample responses only arrive while the sequencer waits for one.
    `BRT_ASSERT_IMP(a_rsp_in_wait, smp_done, state_reg == TOP_WAIT, "sample response outside the wait state")
    // No new vertex is loaded over one that has not been taken.
    `BRT_ASSERT_IMP(a_no_overwrite, load && vout_valid_reg, vtx.ready, "output vertex overwritten")

endmodule

// File: dv/bezier_ribbon_tessellator_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ribbon tessellator core testbench
// Drives curve segments and register writes, predicts every ribbon vertex
// in fixed point and checks the vertex stream under varied flow control.
// ----------------------------------------------------------------------------
module bezier_ribbon_tessellator_core_test;
    import brt_pkg::*;

    localparam int LIMIT_CYCLES = 20000000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TB_MAX_STEPS = 16;

    typedef struct {
        seg_req_t s;
        bit       typed;
        vertex_t  first;
    } dir_row_t;

    logic clk;
    logic rst_n;

    brt_stream_if #(.payload_t(cfg_req_t)) cfg_if ();
    brt_stream_if #(.payload_t(seg_req_t)) seg_if ();
    brt_stream_if #(.payload_t(vertex_t))  vtx_if ();

    bezier_ribbon_tessellator_core #(.MAX_STEPS(TB_MAX_STEPS)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .seg   (seg_if),
        .vtx   (vtx_if)
    );

    // Shadow copy of the two registers.
    logic [THICK_W-1:0] thick_shadow;
    logic [STEPS_W-1:0] steps_shadow;

    vertex_t expected_vertices[$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_reqs;
    int      hold_done;
    int      hold_left;
    longint  cycles;
    dir_row_t dir_rows[11];

    // Clock generation.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_div(longint a, longint d);
        if (a >= 0)
            return a / d;
        return -((-a + d - 1) / d);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Curve point and side offset at parameter k/n.
    task automatic curve_sample(input longint p[4][3], input longint n, input longint k,
                                output longint pt[3], output longint off[2], output bit deg);
        longint u, c0, c1, c2, c3, d, e0, e1, e2, dx, dy, num;
        longint unsigned ax, ay, m, len, mx, my, th;
        u  = n - k;
        c0 = u * u * u;
        c1 = 3 * u * u * k;
        c2 = 3 * u * k * k;
        c3 = k * k * k;
        d  = n * n * n;
        e0 = u * u;
        e1 = 2 * u * k;
        e2 = k * k;
        for (int a = 0; a < 3; a++)
        begin
            num = c0 * p[0][a] + c1 * p[1][a] + c2 * p[2][a] + c3 * p[3][a];
            pt[a] = floor_div(num + d / 2, d);
        end
        dx = e0 * (p[1][0] - p[0][0]) + e1 * (p[2][0] - p[1][0]) + e2 * (p[3][0] - p[2][0]);
        dy = e0 * (p[1][1] - p[0][1]) + e1 * (p[2][1] - p[1][1]) + e2 * (p[3][1] - p[2][1]);
        if (dx == 0 && dy == 0)
        begin
            off[0] = 0;
            off[1] = 0;
            deg = 1'b1;
            return;
        end
        deg = 1'b0;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        m  = (ax > ay) ? ax : ay;
        while (m >= (64'd1 << 30))
        begin
            ax = ax >> 1;
            ay = ay >> 1;
            m  = m >> 1;
        end
        while (m < (64'd1 << 29))
        begin
            ax = ax << 1;
            ay = ay << 1;
            m  = m << 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        th  = thick_shadow;
        mx  = (th * ay + len) / (2 * len);
        my  = (th * ax + len) / (2 * len);
        off[0] = (dy < 0) ? -longint'(mx) : longint'(mx);
        off[1] = (dx > 0) ? -longint'(my) : longint'(my);
    endtask

    function automatic vertex_t make_vertex(longint pt[3], longint off[2], int sgn,
                                            corner_t c, bit deg, bit lst);
        vertex_t v;
        longint  tx;
        longint  ty;
        tx = clamp32(pt[0] + sgn * off[0]);
        ty = clamp32(pt[1] + sgn * off[1]);
        v.vertex_x   = tx[31:0];
        v.vertex_y   = ty[31:0];
        v.vertex_z   = pt[2][31:0];
        v.corner     = c;
        v.degenerate = deg;
        v.last       = lst;
        return v;
    endfunction

    // Adds one vertex at the tail of the expected list.
    function automatic void append_vertex(vertex_t v);
        expected_vertices.insert(expected_vertices.size(), v);
    endfunction

    // Queues every ribbon vertex of one segment; returns how many.
    task automatic predict_ribbon(input seg_req_t s, output int cnt);
        longint p[4][3];
        longint cpt[3], coff[2], npt[3], noff[2];
        bit     cdeg, ndeg;
        longint n;
        logic [383:0] bits;
        bits = s;
        for (int i = 0; i < 12; i++)
            p[i / 3][i % 3] = longint'($signed(bits[383 - 32 * i -: 32]));
        n = steps_shadow;
        if (n < 1)
            n = 1;
        if (n > TB_MAX_STEPS)
            n = TB_MAX_STEPS;
        cnt = 0;
        curve_sample(p, n, 0, cpt, coff, cdeg);
        for (longint k = 0; k < n; k++)
        begin
            curve_sample(p, n, k + 1, npt, noff, ndeg);
            append_vertex(make_vertex(cpt, coff, -1, CORNER_CUR_MINUS, cdeg, 0));
            append_vertex(make_vertex(cpt, coff, 1, CORNER_CUR_PLUS, cdeg, 0));
            append_vertex(make_vertex(npt, noff, 1, CORNER_NXT_PLUS, ndeg, 0));
            append_vertex(make_vertex(npt, noff, -1, CORNER_NXT_MINUS, ndeg, k == n - 1));
            cnt = cnt + 4;
            cpt  = npt;
            coff = noff;
            cdeg = ndeg;
        end
    endtask

    // Vertex checker and receiver flow control.
    always @(posedge clk)
    begin
        vertex_t got;
        vertex_t exp_v;
        if (rst_n && vtx_if.valid && vtx_if.ready)
        begin
            got = vtx_if.payload;
            if (expected_vertices.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected vertex x=%h y=%h z=%h", got.vertex_x, got.vertex_y,
                             got.vertex_z);
            end
            else
            begin
                exp_v = expected_vertices.pop_front();
                if (got.vertex_x !== exp_v.vertex_x || got.vertex_y !== exp_v.vertex_y ||
                    got.vertex_z !== exp_v.vertex_z || got.corner !== exp_v.corner ||
                    got.degenerate !== exp_v.degenerate || got.last !== exp_v.last)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("vertex mismatch exp x=%h y=%h z=%h c=%0d d=%b l=%b got x=%h y=%h z=%h c=%0d d=%b l=%b",
                                 exp_v.vertex_x, exp_v.vertex_y, exp_v.vertex_z,
                                 exp_v.corner, exp_v.degenerate, exp_v.last,
                                 got.vertex_x, got.vertex_y, got.vertex_z,
                                 got.corner, got.degenerate, got.last);
                end
            end
        end
        // A long hold-off takes priority over random stalls.
        if (hold_reqs != hold_done)
        begin
            hold_done = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            vtx_if.ready <= 1'b0;
        end
        else
            vtx_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid         <= 1'b1;
        cfg_if.payload.index <= idx;
        cfg_if.payload.data  <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == CFG_THICKNESS)
            thick_shadow = data[THICK_W-1:0];
        else if (idx == CFG_STEPS)
            steps_shadow = data[STEPS_W-1:0];
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Writes an index outside the register list, which must be ignored.
    task automatic write_bad_index(input logic [CFG_INDEX_W-1:0] idx);
        cfg_if.valid         <= 1'b1;
        cfg_if.payload.index <= idx;
        cfg_if.payload.data  <= $urandom;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one segment, with an optional idle gap, and predicts it on acceptance.
    task automatic send_segment(input seg_req_t s, output int cnt);
        if ($urandom_range(99) < send_idle_pct)
        begin
            seg_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        seg_if.valid   <= 1'b1;
        seg_if.payload <= s;
        do
            @(posedge clk);
        while (!seg_if.ready);
        predict_ribbon(s, cnt);
    endtask

    task automatic drain;
        seg_if.valid <= 1'b0;
        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(logic [31:0] prev);
        int sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return $urandom;
        if (sel < 75)
            return $urandom_range(32'h00200000) - 32'h00100000;
        if (sel < 85)
            return ($urandom_range(1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
        return prev;
    endfunction

    function automatic seg_req_t rand_segment();
        logic [383:0] bits;
        logic [31:0]  f[12];
        for (int i = 0; i < 12; i++)
            f[i] = rand_coord((i >= 3) ? f[i - 3] : 32'h0);
        bits = '0;
        for (int i = 0; i < 12; i++)
            bits = (bits << 32) | f[i];
        return seg_req_t'(bits);
    endfunction

    function automatic vertex_t typed_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                             bit deg);
        vertex_t v;
        v.vertex_x   = x;
        v.vertex_y   = y;
        v.vertex_z   = z;
        v.corner     = CORNER_CUR_MINUS;
        v.degenerate = deg;
        v.last       = 1'b0;
        return v;
    endfunction

    task automatic run_random(input int items, input int max_steps);
        int cnt;
        for (int i = 0; i < items; i++)
            send_segment(rand_segment(), cnt);
        drain();
        if (max_steps > 0)
            write_reg(CFG_STEPS, $urandom_range(max_steps, 1));
    endtask

    // Main sequence.
    initial
    begin
        int cnt;
        cycles = 0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_reqs = 0;
        hold_done = 0;
        hold_left = 0;
        thick_shadow = 31'd65536;
        steps_shadow = 5'd12;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        seg_if.valid = 1'b0;
        seg_if.payload = '0;
        vtx_if.ready = 1'b0;

        // Directed rows: points given as x, y, z of start, ctrl1, ctrl2, end.
        dir_rows[0] = '{seg_req_t'('0), 1, typed_vertex(32'h0, 32'h0, 32'h0, 1)};
        dir_rows[1] = '{seg_req_t'({12{32'h7FFFFFFF}}), 1,
                        typed_vertex(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1)};
        dir_rows[2] = '{seg_req_t'({12{32'h80000000}}), 1,
                        typed_vertex(32'h80000000, 32'h80000000, 32'h80000000, 1)};
        dir_rows[3] = '{seg_req_t'({32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0,
                        32'h00020000, 32'h0, 32'h0, 32'h00030000, 32'h0, 32'h0}), 0, '0};
        dir_rows[4] = '{seg_req_t'({32'h0, 32'h00030000, 32'h0, 32'h0, 32'h00020000, 32'h0,
                        32'h0, 32'h00010000, 32'h0, 32'h0, 32'h0, 32'h0}), 0, '0};
        dir_rows[5] = '{seg_req_t'({32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h80000000,
                        32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}), 0, '0};
        dir_rows[6] = '{seg_req_t'({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                        32'h00050000, 32'h00050000, 32'h0, 32'h000A0000, 32'h0, 32'h0}), 0, '0};
        dir_rows[7] = '{seg_req_t'({32'h0, 32'h0, 32'h0, 32'h00050000, 32'h00050000, 32'h0,
                        32'h000A0000, 32'h0, 32'h0, 32'h000A0000, 32'h0, 32'h0}), 0, '0};
        dir_rows[8] = '{seg_req_t'({32'h0, 32'h0, 32'h0, 32'h000A0000, 32'h000A0000, 32'h0,
                        32'hFFF60000, 32'h000A0000, 32'h0, 32'h0, 32'h0, 32'h0}), 0, '0};
        dir_rows[9] = '{seg_req_t'({32'h0, 32'h0, 32'h80000000, 32'h00010000, 32'h00010000,
                        32'h7FFFFFFF, 32'h00020000, 32'h0, 32'h80000000, 32'h00030000,
                        32'h00010000, 32'h7FFFFFFF}), 0, '0};
        dir_rows[10] = '{seg_req_t'({32'h0, 32'h0, 32'h0, 32'h000A0000, 32'h000A0000, 32'h0,
                         32'h0, 32'h000A0000, 32'h0, 32'h000A0000, 32'h0, 32'h0}), 0, '0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Directed part at reset settings with no idling.
        foreach (dir_rows[i])
        begin
            send_segment(dir_rows[i].s, cnt);
            if (dir_rows[i].typed)
                expected_vertices[expected_vertices.size() - cnt] = dir_rows[i].first;
        end
        drain();

        // Widest ribbon with a single step; the sender idles.
        write_reg(CFG_THICKNESS, 32'hFFFFFFFF);
        write_reg(CFG_STEPS, 32'd1);
        send_idle_pct = 62;
        run_random(40, 0);

        // Zero width and zero steps; the receiver stalls.
        write_reg(CFG_THICKNESS, 32'h0);
        write_reg(CFG_STEPS, 32'd0);
        write_bad_index(4'd5);
        send_idle_pct = 0;
        recv_stall_pct = 62;
        run_random(30, 0);

        // Steps above the maximum saturate; both sides idle lightly.
        write_reg(CFG_THICKNESS, $urandom);
        write_reg(CFG_STEPS, 32'd31);
        write_bad_index(4'd15);
        send_idle_pct = 13;
        recv_stall_pct = 13;
        run_random(3, 0);

        // Long receiver hold-off while segments keep coming.
        write_reg(CFG_THICKNESS, 32'd65536);
        write_reg(CFG_STEPS, 32'd16);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_reqs = hold_reqs + 1;
        run_random(3, 3);

        // Mixed phases with small step counts and random widths.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_THICKNESS, (ph == 0) ? 32'h7FFFFFFF : $urandom_range(32'h00400000));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int i = 0; i < 18; i++)
                send_segment(rand_segment(), cnt);
            // The sender pauses until the block has caught up.
            drain();
            run_random(19, 4);
        end

        drain();
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/brt_pkg.sv
hw/rtl/brt_stream_if.sv
hw/rtl/brt_divider.sv
hw/rtl/brt_isqrt.sv
hw/rtl/brt_sampler.sv
hw/rtl/bezier_ribbon_tessellator_core.sv
dv/bezier_ribbon_tessellator_core_test.sv
